// ===== design/sic_pkg.sv =====
// shared types and constants for the secondary interrupt controller
// no dependencies; imported by secondary_interrupt_controller
`timescale 1ns / 1ps
`default_nettype none

package sic_pkg;

    // number of interrupt sources, one bit each in every register
    localparam int NUM_SOURCES = 23;
    localparam int IDX_W       = $clog2(NUM_SOURCES);

    typedef logic [NUM_SOURCES-1:0] src_vec_t;

    // item kinds
    typedef enum logic [1:0] {
        KIND_READ   = 2'd0,
        KIND_WRITE  = 2'd1,
        KIND_SAMPLE = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    // register word offsets
    localparam logic [3:0] OFF_SELECT   = 4'd0;
    localparam logic [3:0] OFF_ENABLE   = 4'd1;
    localparam logic [3:0] OFF_ENCLR    = 4'd2;
    localparam logic [3:0] OFF_ENSET    = 4'd3;
    localparam logic [3:0] OFF_TYPE     = 4'd4;
    localparam logic [3:0] OFF_POLARITY = 4'd5;
    localparam logic [3:0] OFF_SECURITY = 4'd6;
    localparam logic [3:0] OFF_IRQSTAT  = 4'd7;
    localparam logic [3:0] OFF_FIQSTAT  = 4'd8;
    localparam logic [3:0] OFF_RAW      = 4'd9;
    localparam logic [3:0] OFF_CLEAR    = 4'd10;
    localparam logic [3:0] OFF_SOFT     = 4'd11;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] reg_offset;
        src_vec_t   write_value;
        src_vec_t   source_lines;
    } sic_req_t;

    typedef struct packed {
        src_vec_t         read_value;
        logic             irq_line;
        logic             fiq_line;
        logic             pending_valid;
        logic [IDX_W-1:0] pending_index;
    } sic_rsp_t;

    // lowest set bit of a source vector, zero when none is set
    function automatic logic [IDX_W-1:0] lowest_set(input src_vec_t v);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = NUM_SOURCES - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

// ===== design/secondary_interrupt_controller.sv =====
// secondary interrupt controller: 23 sources behind word registers
// the response is valid once an item has passed the request register, then the state
// update and response register; throughput one item per cycle while the response side
// does not stall, set by the state update plus priority encoder
// rst_n asynchronously clears all source registers and both pipeline valids
// depends on sic_pkg
`timescale 1ns / 1ps
`default_nettype none

module secondary_interrupt_controller (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire sic_pkg::sic_req_t req,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    output sic_pkg::sic_rsp_t      rsp
);
    import sic_pkg::*;

    // request stage
    logic     req_valid_reg;
    sic_req_t req_reg;

    // source state
    src_vec_t enable_reg,   enable_next;
    src_vec_t type_reg,     type_next;
    src_vec_t polarity_reg, polarity_next;
    src_vec_t select_reg,   select_next;
    src_vec_t latch_reg,    latch_next;
    src_vec_t lines_reg,    lines_next;
    src_vec_t soft_reg,     soft_next;

    // response stage
    logic     rsp_valid_reg;
    sic_rsp_t rsp_reg, rsp_next;

    logic     advance;
    src_vec_t raw_cur, irq_cur, fiq_cur;
    src_vec_t raw_new, irq_new, fiq_new;
    src_vec_t read_data;
    src_vec_t edge_det;

    // pipeline flow control
    assign advance   = req_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !req_valid_reg || advance;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            req_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            req_reg <= req;
        end
    end

    // status from the current state, used by reads
    always_comb
    begin
        raw_cur = ((lines_reg ^ polarity_reg) & ~type_reg) | (latch_reg & type_reg) | soft_reg;
        irq_cur = raw_cur & enable_reg & ~select_reg;
        fiq_cur = raw_cur & enable_reg & select_reg;
    end

    // read mux
    always_comb
    begin
        case (req_reg.reg_offset)
            OFF_SELECT:   read_data = select_reg;
            OFF_ENABLE:   read_data = enable_reg;
            OFF_ENCLR:    read_data = enable_reg;
            OFF_ENSET:    read_data = enable_reg;
            OFF_TYPE:     read_data = type_reg;
            OFF_POLARITY: read_data = polarity_reg;
            OFF_IRQSTAT:  read_data = irq_cur;
            OFF_FIQSTAT:  read_data = fiq_cur;
            OFF_RAW:      read_data = raw_cur;
            OFF_SOFT:     read_data = soft_reg;
            default:      read_data = '0;
        endcase
    end

    // edge detection on a line sample
    assign edge_det = ((req_reg.source_lines & ~lines_reg) & ~polarity_reg)
                    | ((lines_reg & ~req_reg.source_lines) & polarity_reg);

    // next source state
    always_comb
    begin
        enable_next   = enable_reg;
        type_next     = type_reg;
        polarity_next = polarity_reg;
        select_next   = select_reg;
        latch_next    = latch_reg;
        lines_next    = lines_reg;
        soft_next     = soft_reg;
        if (req_reg.kind == KIND_WRITE)
        begin
            case (req_reg.reg_offset)
                OFF_SELECT:   select_next   = req_reg.write_value;
                OFF_ENABLE:   enable_next   = req_reg.write_value;
                OFF_ENCLR:    enable_next   = enable_reg & ~req_reg.write_value;
                OFF_ENSET:    enable_next   = enable_reg | req_reg.write_value;
                OFF_TYPE:     type_next     = req_reg.write_value;
                OFF_POLARITY: polarity_next = req_reg.write_value;
                OFF_CLEAR:    latch_next    = latch_reg & ~req_reg.write_value;
                OFF_SOFT:     soft_next     = req_reg.write_value;
                default:      ;
            endcase
        end
        else if (req_reg.kind == KIND_SAMPLE)
        begin
            latch_next = latch_reg | (edge_det & type_reg);
            lines_next = req_reg.source_lines;
        end
    end

    // status after the step and response assembly
    always_comb
    begin
        raw_new = ((lines_next ^ polarity_next) & ~type_next) | (latch_next & type_next)
                | soft_next;
        irq_new = raw_new & enable_next & ~select_next;
        fiq_new = raw_new & enable_next & select_next;
        rsp_next.read_value    = (req_reg.kind == KIND_READ) ? read_data : '0;
        rsp_next.irq_line      = |irq_new;
        rsp_next.fiq_line      = |fiq_new;
        rsp_next.pending_valid = |irq_new;
        rsp_next.pending_index = lowest_set(irq_new);
    end

    // source state registers, updated when an item moves to the response stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg   <= '0;
            type_reg     <= '0;
            polarity_reg <= '0;
            select_reg   <= '0;
            latch_reg    <= '0;
            lines_reg    <= '0;
            soft_reg     <= '0;
        end
        else if (advance)
        begin
            enable_reg   <= enable_next;
            type_reg     <= type_next;
            polarity_reg <= polarity_next;
            select_reg   <= select_next;
            latch_reg    <= latch_next;
            lines_reg    <= lines_next;
            soft_reg     <= soft_next;
        end
    end

    // response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // irq line and pending flag come from the same status vector
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.pending_valid == rsp.irq_line))
        else $error("pending_valid disagrees with irq_line");

    // no pending source means index zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.pending_valid) |-> (rsp.pending_index == '0))
        else $error("pending_index nonzero with nothing pending");

    // only reads return data
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && req_reg.kind != KIND_READ) |=> (rsp.read_value == '0))
        else $error("read data on a non-read transfer");

    // a stalled request stage keeps its item
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid_reg && !advance) |=> (req_valid_reg && $stable(req_reg)))
        else $error("request stage lost an item while stalled");

    // source state changes only when an item advances
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> ($stable(enable_reg) && $stable(latch_reg) && $stable(lines_reg)))
        else $error("source state changed without a transfer");

endmodule

`default_nettype wire

// ===== tb/sic_checker.sv =====
`timescale 1ns / 1ps
// sic_checker: watches both channels of the interrupt controller, keeps its own copy of
// the source registers, predicts every response and compares it field by field
// depends on sic_pkg
module sic_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_ready,
    input  sic_pkg::sic_req_t req,
    input  logic              rsp_valid,
    input  logic              rsp_ready,
    input  sic_pkg::sic_rsp_t rsp,
    output int                errors,
    output int                awaited
);
    import sic_pkg::*;

    // predicted register state
    src_vec_t enabled;
    src_vec_t edge_typed;
    src_vec_t active_low;
    src_vec_t fast_routed;
    src_vec_t edges_seen;
    src_vec_t last_lines;
    src_vec_t soft_set;

    // responses predicted but not yet seen
    sic_rsp_t awaited_rsp[$];

    initial
    begin
        errors  = 0;
        awaited = 0;
    end

    task automatic report_mismatch(input string msg);
        errors++;
        $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    // level sources follow the lines, edge sources the latch, soft bits always count
    function automatic src_vec_t raw_status();
        src_vec_t level;
        level = last_lines ^ active_low;
        return (level & ~edge_typed) | (edges_seen & edge_typed) | soft_set;
    endfunction

    function automatic src_vec_t read_register(input logic [3:0] off);
        case (off)
            OFF_SELECT:                       return fast_routed;
            OFF_ENABLE, OFF_ENCLR, OFF_ENSET: return enabled;
            OFF_TYPE:                         return edge_typed;
            OFF_POLARITY:                     return active_low;
            OFF_IRQSTAT:                      return raw_status() & enabled & ~fast_routed;
            OFF_FIQSTAT:                      return raw_status() & enabled & fast_routed;
            OFF_RAW:                          return raw_status();
            OFF_SOFT:                         return soft_set;
            default:                          return '0;
        endcase
    endfunction

    // read-only and unused offsets fall through untouched
    function automatic void write_register(input logic [3:0] off, input src_vec_t v);
        case (off)
            OFF_SELECT:   fast_routed = v;
            OFF_ENABLE:   enabled = v;
            OFF_ENCLR:    enabled = enabled & ~v;
            OFF_ENSET:    enabled = enabled | v;
            OFF_TYPE:     edge_typed = v;
            OFF_POLARITY: active_low = v;
            OFF_CLEAR:    edges_seen = edges_seen & ~v;
            OFF_SOFT:     soft_set = v;
            default:      ;
        endcase
    endfunction

    // apply one request to the predicted state and build the response it causes
    function automatic sic_rsp_t step_controller(input sic_req_t r);
        sic_rsp_t o;
        src_vec_t moved;
        src_vec_t irqs;
        src_vec_t fiqs;
        bit       found;
        o = '0;
        found = 1'b0;
        case (r.kind)
            KIND_READ:  o.read_value = read_register(r.reg_offset);
            KIND_WRITE: write_register(r.reg_offset, r.write_value);
            KIND_SAMPLE:
            begin
                // rising edge for active high, falling edge for active low
                moved = (r.source_lines & ~last_lines & ~active_low)
                      | (~r.source_lines & last_lines & active_low);
                edges_seen = edges_seen | (moved & edge_typed);
                last_lines = r.source_lines;
            end
            default: ;
        endcase
        irqs = raw_status() & enabled & ~fast_routed;
        fiqs = raw_status() & enabled & fast_routed;
        o.irq_line      = |irqs;
        o.fiq_line      = |fiqs;
        o.pending_valid = |irqs;
        // lowest pending normal source wins
        for (int i = 0; i < NUM_SOURCES; i++)
        begin
            if (irqs[i] && !found)
            begin
                o.pending_index = IDX_W'(i);
                found = 1'b1;
            end
        end
        return o;
    endfunction

    // compare each response transfer, predict on each request transfer
    always @(posedge clk or negedge rst_n)
    begin : watch
        sic_rsp_t want;
        if (!rst_n)
        begin
            enabled     = '0;
            edge_typed  = '0;
            active_low  = '0;
            fast_routed = '0;
            edges_seen  = '0;
            last_lines  = '0;
            soft_set    = '0;
            awaited_rsp.delete();
            awaited = 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (awaited_rsp.size() == 0)
                begin
                    report_mismatch("response with none awaited");
                end
                else
                begin
                    want = awaited_rsp.pop_front();
                    if (rsp.read_value !== want.read_value)
                        report_mismatch($sformatf("read_value %h, expected %h",
                                                  rsp.read_value, want.read_value));
                    if (rsp.irq_line !== want.irq_line)
                        report_mismatch($sformatf("irq_line %b, expected %b",
                                                  rsp.irq_line, want.irq_line));
                    if (rsp.fiq_line !== want.fiq_line)
                        report_mismatch($sformatf("fiq_line %b, expected %b",
                                                  rsp.fiq_line, want.fiq_line));
                    if (rsp.pending_valid !== want.pending_valid)
                        report_mismatch($sformatf("pending_valid %b, expected %b",
                                                  rsp.pending_valid, want.pending_valid));
                    if (rsp.pending_index !== want.pending_index)
                        report_mismatch($sformatf("pending_index %0d, expected %0d",
                                                  rsp.pending_index, want.pending_index));
                end
            end
            if (req_valid && req_ready)
            begin
                awaited_rsp.push_back(step_controller(req));
            end
            awaited = awaited_rsp.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// tb: drives register reads, writes and line samples into the interrupt controller
// with random idling on both sides; sic_checker does the prediction and comparison
// depends on sic_pkg, sic_checker and secondary_interrupt_controller
module tb;
    import sic_pkg::*;

    localparam int CYCLE_LIMIT      = 1_000_000;
    localparam int RESET_CYCLES     = 8;
    localparam int TAIL_CYCLES      = 16;
    localparam int RANDOM_ITEMS     = 1775;
    localparam int DRAIN_AFTER      = 1200;
    localparam int LONG_HOLD_AFTER  = 500;
    localparam int LONG_HOLD_CYCLES = 200;
    localparam int MODE_SPAN        = 150;

    // offsets with no register behind them
    localparam logic [3:0] OFF_UNUSED_LO = 4'd12;
    localparam logic [3:0] OFF_UNUSED_HI = 4'd15;
    localparam src_vec_t   ALL_SOURCES   = '1;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_ready;
    sic_req_t req       = '0;
    logic     rsp_valid;
    logic     rsp_ready = 1'b0;
    sic_rsp_t rsp;
    int       errors;
    int       awaited;
    int       offered   = 0;
    int       tx_mode   = 1;
    int       cycle_count = 0;
    src_vec_t lines_now = '0;

    secondary_interrupt_controller uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    sic_checker chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .errors    (errors),
        .awaited   (awaited)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // idle stretch: mostly short, a few long
    function automatic int idle_length();
        if ($urandom_range(0, 99) < 75)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int sender_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (tx_mode == 0)
            return 0;
        if (roll < ((tx_mode == 1) ? 60 : 30))
            return 0;
        return idle_length();
    endfunction

    // source masks: dense, sparse, single bit, shifted, extremes
    function automatic src_vec_t pick_bits();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return ALL_SOURCES;
            2:       return src_vec_t'(1) << $urandom_range(0, NUM_SOURCES - 1);
            3:       return src_vec_t'($urandom) & src_vec_t'($urandom) & src_vec_t'($urandom);
            4:       return src_vec_t'($urandom) << $urandom_range(0, NUM_SOURCES - 1);
            default: return src_vec_t'($urandom);
        endcase
    endfunction

    function automatic sic_req_t compose(input kind_t k, input logic [3:0] off,
                                         input src_vec_t wv, input src_vec_t lines);
        sic_req_t r;
        r.kind         = k;
        r.reg_offset   = off;
        r.write_value  = wv;
        r.source_lines = lines;
        return r;
    endfunction

    // mostly driver-like traffic: line samples, register setup, status reads, some noise
    function automatic sic_req_t random_request();
        sic_req_t r;
        int       roll;
        roll = $urandom_range(0, 99);
        r = compose(KIND_READ, OFF_SELECT, pick_bits(), src_vec_t'($urandom));
        if (roll < 40)
        begin
            lines_now = lines_now ^ pick_bits();
            r.kind = KIND_SAMPLE;
            r.source_lines = lines_now;
        end
        else if (roll < 62)
        begin
            r.kind = KIND_WRITE;
            case ($urandom_range(0, 7))
                0:       r.reg_offset = OFF_SELECT;
                1:       r.reg_offset = OFF_ENABLE;
                2:       r.reg_offset = OFF_ENCLR;
                3:       r.reg_offset = OFF_ENSET;
                4:       r.reg_offset = OFF_TYPE;
                5:       r.reg_offset = OFF_POLARITY;
                6:       r.reg_offset = OFF_CLEAR;
                default: r.reg_offset = OFF_SOFT;
            endcase
        end
        else if (roll < 92)
        begin
            r.kind = KIND_READ;
            if ($urandom_range(0, 99) < 40)
                r.reg_offset = 4'($urandom_range(OFF_IRQSTAT, OFF_RAW));
            else
                r.reg_offset = 4'($urandom_range(OFF_SELECT, OFF_SOFT));
        end
        else if (roll < 97)
        begin
            r.kind = 2'($urandom_range(KIND_READ, KIND_NONE));
            r.reg_offset = 4'($urandom_range(OFF_SELECT, OFF_UNUSED_HI));
            r.write_value = src_vec_t'($urandom);
        end
        else
        begin
            r.kind = 2'($urandom_range(KIND_READ, KIND_WRITE));
            r.reg_offset = 4'($urandom_range(OFF_UNUSED_LO, OFF_UNUSED_HI));
        end
        return r;
    endfunction

    task automatic wait_drained();
        @(negedge clk);
        while (awaited != 0)
            @(negedge clk);
    endtask

    // hold one request until its transfer, then idle or keep valid up
    task automatic offer(input sic_req_t r);
        int gap;
        req <= r;
        req_valid <= 1'b1;
        do @(posedge clk); while (!req_ready);
        offered++;
        if (offered % MODE_SPAN == 0)
            tx_mode = $urandom_range(0, 2);
        gap = sender_gap();
        if (offered == DRAIN_AFTER)
        begin
            // pause until every response has come back
            req_valid <= 1'b0;
            wait_drained();
            @(posedge clk);
        end
        else if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // response side: random stalls, quiet stretches, one long hold to back up the pipe
    initial
    begin : receiver
        int delivered;
        int hold;
        int rx_mode;
        bit long_done;
        delivered = 0;
        hold = 0;
        rx_mode = 1;
        long_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_valid && rsp_ready)
            begin
                delivered++;
                if (delivered % MODE_SPAN == 0)
                    rx_mode = $urandom_range(0, 2);
            end
            if (!long_done && delivered >= LONG_HOLD_AFTER)
            begin
                long_done = 1'b1;
                hold = LONG_HOLD_CYCLES;
            end
            if (hold > 0)
            begin
                hold--;
                rsp_ready <= 1'b0;
            end
            else if (rx_mode == 0 || $urandom_range(0, 99) < ((rx_mode == 1) ? 70 : 40))
            begin
                rsp_ready <= 1'b1;
            end
            else
            begin
                hold = idle_length() - 1;
                rsp_ready <= 1'b0;
            end
        end
    end

    // stimulus and verdict
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values, level sources, fast routing, edge latching and clearing, enable clear and set, soft bits
        offer(compose(KIND_READ,  OFF_RAW,       '0,            '0));
        offer(compose(KIND_READ,  OFF_SECURITY,  '0,            '0));
        offer(compose(KIND_WRITE, OFF_ENABLE,    ALL_SOURCES,   '0));
        offer(compose(KIND_SAMPLE, OFF_SELECT,   '0,            ALL_SOURCES));
        offer(compose(KIND_READ,  OFF_IRQSTAT,   '0,            '0));
        offer(compose(KIND_WRITE, OFF_SELECT,    23'h3FFFFF,    '0));
        offer(compose(KIND_READ,  OFF_FIQSTAT,   '0,            '0));
        offer(compose(KIND_WRITE, OFF_SELECT,    '0,            '0));
        offer(compose(KIND_WRITE, OFF_POLARITY,  ALL_SOURCES,   '0));
        offer(compose(KIND_WRITE, OFF_TYPE,      ALL_SOURCES,   '0));
        offer(compose(KIND_SAMPLE, OFF_SELECT,   '0,            '0));
        offer(compose(KIND_READ,  OFF_RAW,       '0,            '0));
        offer(compose(KIND_WRITE, OFF_CLEAR,     23'h3FFFFF,    '0));
        offer(compose(KIND_WRITE, OFF_ENCLR,     23'h400000,    '0));
        offer(compose(KIND_READ,  OFF_ENSET,     '0,            '0));
        offer(compose(KIND_WRITE, OFF_ENSET,     23'h400000,    '0));
        offer(compose(KIND_WRITE, OFF_CLEAR,     ALL_SOURCES,   '0));
        offer(compose(KIND_WRITE, OFF_SOFT,      23'h000001,    '0));
        offer(compose(KIND_READ,  OFF_SOFT,      '0,            '0));
        // read-only, unused offsets and the unused kind
        offer(compose(KIND_WRITE, OFF_SECURITY,  ALL_SOURCES,   '0));
        offer(compose(KIND_WRITE, OFF_IRQSTAT,   ALL_SOURCES,   '0));
        offer(compose(KIND_NONE,  OFF_UNUSED_HI, ALL_SOURCES,   ALL_SOURCES));
        offer(compose(KIND_READ,  OFF_UNUSED_HI, '0,            '0));
        offer(compose(KIND_WRITE, OFF_UNUSED_LO, ALL_SOURCES,   '0));
        offer(compose(KIND_READ,  OFF_CLEAR,     '0,            '0));
        lines_now = '0;

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            offer(random_request());
        end

        req_valid <= 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0 && awaited == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
